>>> rtl/srle_pkg.sv
`timescale 1ns / 1ps

package srle_pkg;

    localparam int DIM_W   = 12;
    localparam int TOTAL_W = 24;
    localparam int COL_W   = 16;
    localparam int ROWB_W  = 17;
    localparam int BYTE_W  = 8;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [ROWB_W-1:0] ROW_HEADER_BYTES = 17'd2;

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [TOTAL_W-1:0] total;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] pixel_value;
        logic [BYTE_W-1:0] repeat_count;
        logic              frame_full;
    } result_t;

endpackage

>>> rtl/srle_cfg.sv
`timescale 1ns / 1ps

module srle_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [srle_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [srle_pkg::DIM_W-1:0]        wr_data,
    output srle_pkg::cfg_t                    cfg
);

    logic [srle_pkg::DIM_W-1:0]   width_reg;
    logic [srle_pkg::DIM_W-1:0]   height_reg;
    logic [srle_pkg::TOTAL_W-1:0] total_reg;
    logic [srle_pkg::TOTAL_W-1:0] total_next;

    // 12x12 product always fits in 24 bits
    assign total_next = srle_pkg::TOTAL_W'(width_reg) * srle_pkg::TOTAL_W'(height_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= '0;
            height_reg <= '0;
            total_reg  <= '0;
        end
        else
        begin
            total_reg <= total_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    srle_pkg::CFG_FRAME_WIDTH:  width_reg  <= wr_data;
                    srle_pkg::CFG_FRAME_HEIGHT: height_reg <= wr_data;
                    default: ;
                endcase
            end
        end
    end

    assign cfg.frame_width  = width_reg;
    assign cfg.frame_height = height_reg;
    assign cfg.total        = total_reg;

endmodule

>>> rtl/srle_decode.sv
`timescale 1ns / 1ps

module srle_decode
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [srle_pkg::BYTE_W-1:0]   data_byte,
    input  logic                          last_byte,
    input  srle_pkg::cfg_t                cfg,
    output srle_pkg::result_t             res
);

    localparam logic [1:0] PH_LEN_LO = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_COUNT  = 2'd3;

    localparam logic [srle_pkg::COL_W-1:0] COL_MAX = '1;

    logic [1:0]                    phase_reg, phase_next;
    logic [srle_pkg::BYTE_W-1:0]   len_lo_reg, len_lo_next;
    logic [srle_pkg::ROWB_W-1:0]   rowb_reg, rowb_next;
    logic [srle_pkg::DIM_W-1:0]    row_reg, row_next;
    logic [srle_pkg::COL_W-1:0]    col_reg, col_next;
    logic [srle_pkg::TOTAL_W-1:0]  pw_reg, pw_next;

    logic [srle_pkg::COL_W-1:0]    row_len;
    logic [srle_pkg::ROWB_W-1:0]   rowb_dec;
    logic [srle_pkg::ROWB_W-1:0]   col_sum;
    logic                          col_below;
    logic [srle_pkg::COL_W-1:0]    col_gap;
    logic [srle_pkg::BYTE_W-1:0]   run_col;
    logic [srle_pkg::TOTAL_W-1:0]  remain;
    logic [srle_pkg::BYTE_W-1:0]   run_len;
    logic [srle_pkg::TOTAL_W-1:0]  pw_lit;
    logic [srle_pkg::TOTAL_W-1:0]  pw_run;

    assign row_len  = {data_byte, len_lo_reg};
    assign rowb_dec = rowb_reg - 1'b1;

    // run clipping against row width, then against pixels left in the frame
    assign col_sum   = {1'b0, col_reg} + srle_pkg::ROWB_W'(data_byte);
    assign col_below = col_reg < srle_pkg::COL_W'(cfg.frame_width);
    assign col_gap   = srle_pkg::COL_W'(cfg.frame_width) - col_reg;
    assign run_col   = (col_sum > srle_pkg::ROWB_W'(cfg.frame_width))
                       ? (col_below ? col_gap[srle_pkg::BYTE_W-1:0] : '0)
                       : data_byte;
    assign remain    = (pw_reg < cfg.total) ? (cfg.total - pw_reg) : '0;
    assign run_len   = (srle_pkg::TOTAL_W'(run_col) > remain)
                       ? remain[srle_pkg::BYTE_W-1:0] : run_col;
    assign pw_lit    = pw_reg + 1'b1;
    assign pw_run    = pw_reg + srle_pkg::TOTAL_W'(run_len);

    always_comb
    begin
        phase_next  = phase_reg;
        len_lo_next = len_lo_reg;
        rowb_next   = rowb_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        pw_next     = pw_reg;
        res         = '0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_LEN_LO:
                begin
                    if (row_reg < cfg.frame_height)
                    begin
                        len_lo_next = data_byte;
                        phase_next  = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    if (srle_pkg::ROWB_W'(row_len) <= srle_pkg::ROW_HEADER_BYTES)
                    begin
                        row_next   = row_reg + 1'b1;
                        col_next   = '0;
                        rowb_next  = '0;
                        phase_next = PH_LEN_LO;
                    end
                    else
                    begin
                        rowb_next  = srle_pkg::ROWB_W'(row_len) - srle_pkg::ROW_HEADER_BYTES;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    rowb_next = rowb_dec;
                    if (data_byte != '0)
                    begin
                        if (pw_reg < cfg.total)
                        begin
                            pw_next          = pw_lit;
                            res.valid        = 1'b1;
                            res.pixel_value  = data_byte;
                            res.repeat_count = srle_pkg::BYTE_W'(1);
                            res.frame_full   = (pw_lit == cfg.total);
                        end
                        if (col_reg != COL_MAX)
                            col_next = col_reg + 1'b1;
                        if (rowb_dec == '0)
                        begin
                            row_next   = row_reg + 1'b1;
                            col_next   = '0;
                            rowb_next  = '0;
                            phase_next = PH_LEN_LO;
                        end
                    end
                    else if (rowb_dec == '0)
                    begin
                        // zero in the last row position is dropped
                        row_next   = row_reg + 1'b1;
                        col_next   = '0;
                        rowb_next  = '0;
                        phase_next = PH_LEN_LO;
                    end
                    else
                    begin
                        rowb_next  = rowb_dec - 1'b1;
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    if (col_sum > srle_pkg::ROWB_W'(cfg.frame_width))
                        col_next = srle_pkg::COL_W'(cfg.frame_width);
                    else
                        col_next = col_sum[srle_pkg::COL_W-1:0];
                    if (run_len != '0)
                    begin
                        pw_next          = pw_run;
                        res.valid        = 1'b1;
                        res.pixel_value  = '0;
                        res.repeat_count = run_len;
                        res.frame_full   = (pw_run == cfg.total);
                    end
                    if (rowb_reg == '0)
                    begin
                        row_next   = row_reg + 1'b1;
                        col_next   = '0;
                        rowb_next  = '0;
                        phase_next = PH_LEN_LO;
                    end
                    else
                        phase_next = PH_BODY;
                end
                default: ;
            endcase

            if (last_byte)
            begin
                phase_next  = PH_LEN_LO;
                len_lo_next = '0;
                rowb_next   = '0;
                row_next    = '0;
                col_next    = '0;
                pw_next     = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEN_LO;
            len_lo_reg <= '0;
            rowb_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            pw_reg     <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            len_lo_reg <= len_lo_next;
            rowb_reg   <= rowb_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            pw_reg     <= pw_next;
        end
    end

endmodule

>>> rtl/shape_frame_rle_decoder.sv
// A result passes through the input register, the decode logic and the result
// register before it reaches the outputs.
// Throughput: one compressed byte per cycle; a stalled result holds the decoder
// and the input stalls once the input register is also full.
// Reset (rst_n, async, active low) clears decoder state and the frame width,
// height and total registers to zero; no memories, nothing to sweep.
`timescale 1ns / 1ps

module shape_frame_rle_decoder
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        data_byte,
    input  logic                              last_byte,

    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        pixel_value,
    output logic [7:0]                        repeat_count,
    output logic                              frame_full,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [srle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [11:0]                       cfg_data
);

    srle_pkg::cfg_t    cfg;
    srle_pkg::result_t res;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       advance;

    logic       out_valid_reg;
    logic [7:0] pixel_reg;
    logic [7:0] count_reg;
    logic       full_reg;

    assign cfg_ready = 1'b1;

    srle_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // decode moves whenever the result register is free or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    srle_decode u_decode
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_valid_reg & advance),
        .data_byte (byte_reg),
        .last_byte (last_reg),
        .cfg       (cfg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            pixel_reg <= res.pixel_value;
            count_reg <= res.repeat_count;
            full_reg  <= res.frame_full;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_value  = pixel_reg;
    assign repeat_count = count_reg;
    assign frame_full   = full_reg;

endmodule
